/* hdl/jsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_SYMBOL   = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_EOD      = 3'd5;

  // Task queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // One unit of back-end work: a code point and its UTF-8 length, or a
  // single close / error result (len is then 1 and cp is zero)
  typedef struct packed {
    logic [30:0] cp;
    logic [2:0]  len;
    logic [1:0]  kind;
    logic [2:0]  err;
  } jsu_task_t;

endpackage

`default_nettype wire

/* hdl/jsu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic      eod_i,
  output jsu_task_t      task_o,
  output logic           push_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_STR  = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_CONT = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [30:0] cp_q, cp_d;
  logic [2:0]  pend_q, pend_d;

  // Length of the shortest UTF-8 form of a code point
  function automatic logic [2:0] utf8_len(input logic [30:0] cp);
    logic [2:0] n;
    if (cp <= 31'h7F)            n = 3'd1;
    else if (cp <= 31'h7FF)      n = 3'd2;
    else if (cp <= 31'hFFFF)     n = 3'd3;
    else if (cp <= 31'h1FFFFF)   n = 3'd4;
    else if (cp <= 31'h3FFFFFF)  n = 3'd5;
    else                         n = 3'd6;
    return n;
  endfunction

  logic [3:0]  hex_val;
  logic        hex_ok;
  logic [30:0] cp_hex;
  logic [30:0] cp_cont;
  logic [2:0]  pend_dec;

  // Decode one hex digit
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_val = byte_i[3:0];
    end else if ((byte_i >= 8'h41 && byte_i <= 8'h46) ||
                 (byte_i >= 8'h61 && byte_i <= 8'h66)) begin
      hex_val = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_hex   = {cp_q[26:0], hex_val};
  assign cp_cont  = {cp_q[24:0], byte_i[5:0]};
  assign pend_dec = pend_q - 3'd1;

  // Classify the item and build the task for the back end
  always_comb begin
    phase_d     = phase_q;
    cp_d        = cp_q;
    pend_d      = pend_q;
    push_o      = 1'b0;
    task_o.cp   = '0;
    task_o.len  = 3'd1;
    task_o.kind = KIND_DATA;
    task_o.err  = ERR_NONE;
    if (accept_i) begin
      if (eod_i) begin
        push_o      = 1'b1;
        task_o.kind = KIND_ERROR;
        task_o.err  = (phase_q == PH_IDLE) ? ERR_NO_QUOTE : ERR_EOD;
        phase_d     = PH_IDLE;
        cp_d        = '0;
        pend_d      = '0;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (byte_i == 8'h22) begin
              phase_d = PH_STR;
            end else begin
              push_o      = 1'b1;
              task_o.kind = KIND_ERROR;
              task_o.err  = ERR_NO_QUOTE;
              cp_d        = '0;
              pend_d      = '0;
            end
          end
          PH_STR: begin
            if (byte_i == 8'h22) begin
              push_o      = 1'b1;
              task_o.kind = KIND_CLOSE;
              phase_d     = PH_IDLE;
            end else if (byte_i == 8'h5C) begin
              phase_d = PH_ESC;
            end else if ((byte_i < 8'h20 && byte_i != 8'h09 && byte_i != 8'h0D &&
                          byte_i != 8'h0A) || byte_i > 8'hFD ||
                         byte_i[7:6] == 2'b10) begin
              push_o      = 1'b1;
              task_o.kind = KIND_ERROR;
              task_o.err  = ERR_SYMBOL;
              phase_d     = PH_IDLE;
              cp_d        = '0;
              pend_d      = '0;
            end else if (!byte_i[7]) begin
              push_o    = 1'b1;
              task_o.cp = {23'd0, byte_i};
            end else begin
              phase_d = PH_CONT;
              if (byte_i[7:2] == 6'b111111) begin
                pend_d = 3'd5;
                cp_d   = {30'd0, byte_i[0]};
              end else if (byte_i[7:3] == 5'b11111) begin
                pend_d = 3'd4;
                cp_d   = {29'd0, byte_i[1:0]};
              end else if (byte_i[7:4] == 4'b1111) begin
                pend_d = 3'd3;
                cp_d   = {28'd0, byte_i[2:0]};
              end else if (byte_i[7:5] == 3'b111) begin
                pend_d = 3'd2;
                cp_d   = {27'd0, byte_i[3:0]};
              end else begin
                pend_d = 3'd1;
                cp_d   = {26'd0, byte_i[4:0]};
              end
            end
          end
          PH_ESC: begin
            phase_d = PH_STR;
            push_o  = 1'b1;
            case (byte_i)
              8'h22, 8'h5C, 8'h2F: task_o.cp = {23'd0, byte_i};
              8'h62:               task_o.cp = 31'h08;
              8'h66:               task_o.cp = 31'h0C;
              8'h6E:               task_o.cp = 31'h0A;
              8'h74:               task_o.cp = 31'h09;
              8'h72:               task_o.cp = 31'h0D;
              8'h75: begin
                push_o  = 1'b0;
                phase_d = PH_HEX;
                cp_d    = '0;
                pend_d  = 3'd4;
              end
              default: begin
                task_o.kind = KIND_ERROR;
                task_o.err  = ERR_ESCAPE;
                phase_d     = PH_IDLE;
                cp_d        = '0;
                pend_d      = '0;
              end
            endcase
          end
          PH_HEX: begin
            if (!hex_ok) begin
              push_o      = 1'b1;
              task_o.kind = KIND_ERROR;
              task_o.err  = ERR_HEX;
              phase_d     = PH_IDLE;
              cp_d        = '0;
              pend_d      = '0;
            end else begin
              cp_d   = cp_hex;
              pend_d = pend_dec;
              if (pend_dec == 3'd0) begin
                phase_d    = PH_STR;
                push_o     = 1'b1;
                task_o.cp  = cp_hex;
                task_o.len = utf8_len(cp_hex);
              end
            end
          end
          PH_CONT: begin
            if (byte_i[7:6] != 2'b10) begin
              push_o      = 1'b1;
              task_o.kind = KIND_ERROR;
              task_o.err  = ERR_SYMBOL;
              phase_d     = PH_IDLE;
              cp_d        = '0;
              pend_d      = '0;
            end else begin
              cp_d   = cp_cont;
              pend_d = pend_dec;
              if (pend_dec == 3'd0) begin
                phase_d    = PH_STR;
                push_o     = 1'b1;
                task_o.cp  = cp_cont;
                task_o.len = utf8_len(cp_cont);
              end
            end
          end
          default: begin
            push_o      = 1'b1;
            task_o.kind = KIND_ERROR;
            task_o.err  = ERR_SYMBOL;
            phase_d     = PH_IDLE;
            cp_d        = '0;
            pend_d      = '0;
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cp_q    <= '0;
      pend_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cp_q    <= cp_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/jsu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue import jsu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire jsu_task_t task_i,
  input  wire logic      pop_i,
  output jsu_task_t      head_o,
  output logic           valid_o,
  output logic           full_o
);

  jsu_task_t        mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QAW+1)'(QDEPTH));

  // Store pushed tasks
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= task_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/jsu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire jsu_task_t  head_i,
  input  wire logic       head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic [2:0]      out_err_o,
  output logic            out_last_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic [1:0] kind_q;
  logic [2:0] err_q;
  logic       last_q, last_d;
  logic       load;
  logic [2:0] shift_sel;

  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign last_d    = (idx_q == head_i.len - 3'd1);
  assign pop_o     = load && last_d;
  assign idx_d     = last_d ? 3'd0 : idx_q + 3'd1;
  assign shift_sel = head_i.len - 3'd1 - idx_q;

  // Pick the lead byte or the continuation byte at this position
  always_comb begin
    byte_d = 8'h00;
    if (idx_q == 3'd0) begin
      case (head_i.len)
        3'd2:    byte_d = {3'b110, head_i.cp[10:6]};
        3'd3:    byte_d = {4'b1110, head_i.cp[15:12]};
        3'd4:    byte_d = {5'b11110, head_i.cp[20:18]};
        3'd5:    byte_d = {6'b111110, head_i.cp[25:24]};
        3'd6:    byte_d = {7'b1111110, head_i.cp[30]};
        default: byte_d = head_i.cp[7:0];
      endcase
    end else begin
      case (shift_sel)
        3'd1:    byte_d = {2'b10, head_i.cp[11:6]};
        3'd2:    byte_d = {2'b10, head_i.cp[17:12]};
        3'd3:    byte_d = {2'b10, head_i.cp[23:18]};
        3'd4:    byte_d = {2'b10, head_i.cp[29:24]};
        default: byte_d = {2'b10, head_i.cp[5:0]};
      endcase
    end
  end

  // Step through the bytes of the head task
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_d;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      kind_q <= head_i.kind;
      err_q  <= head_i.err;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_err_o   = err_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

/* hdl/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
`default_nettype none

// Decoder for one quoted JSON string value. It takes one text byte per cycle
// on the slave side whenever its four-entry task queue has room, and it gives
// one result per cycle on the master side while m_axis_tready is high and the
// queue holds work. A byte that completes a code point of n UTF-8 bytes (up to
// 6) yields n output bytes; the queue between the parser and the UTF-8 encoder
// absorbs such bursts, so the input side stalls only when the queue is full,
// as when several long code points arrive together or the master side holds off.
// An item's task is queued, and its results are then registered at the output.
// Results of kind 1 close the string, kind 2 report an error code; tlast marks
// the final result caused by one input item.

module json_string_unescape_utf8 import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tuser,   // [0] end_of_data
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [4:0]      m_axis_tuser,   // [1:0] out_kind, [4:2] error_code
  output logic            m_axis_tlast
);

  jsu_task_t push_task;
  jsu_task_t head_task;
  logic      push;
  logic      pop;
  logic      head_valid;
  logic      q_full;
  logic      accept;
  logic [1:0] out_kind;
  logic [2:0] out_err;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eod_i    (s_axis_tuser),
    .task_o   (push_task),
    .push_o   (push)
  );

  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .task_i  (push_task),
    .pop_i   (pop),
    .head_o  (head_task),
    .valid_o (head_valid),
    .full_o  (q_full)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_task),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_kind_o   (out_kind),
    .out_err_o    (out_err),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = {out_err, out_kind};

endmodule

`default_nettype wire
